// File: rtl/ffca_pkg.sv
// Shared types and codes for the first-fit chunk allocator.
// No dependencies.
`timescale 1ns / 1ps
package ffca_pkg;

   localparam int unsigned NEED_W = 18;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_OOM = 2'd1;
   localparam logic [1:0] ST_INV = 2'd2;

   localparam logic CSR_BASE  = 1'b0;
   localparam logic CSR_UNITS = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [16:0] request_bytes;
      logic [31:0] free_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] user_address;
   } rsp_type;

endpackage

// File: rtl/ffca_div.sv
// Divide by a fixed power-of-two divisor with a shift and a mask, result registered.
// Uses ffca_pkg.
`timescale 1ns / 1ps
module ffca_div
   import ffca_pkg::*;
#(
   parameter int unsigned DIVISOR = 16,
   localparam int RW = $clog2(DIVISOR) + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [31:0]   dividend,
   output logic          done,
   output logic [31:0]   quotient,
   output logic [RW-1:0] remainder
);

   localparam int SH = $clog2(DIVISOR);

   logic [RW-1:0] rem_ff, rem_in;
   logic [31:0]   quo_ff, quo_in;
   logic          done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      done_in = start;
      if (start) begin
         quo_in = dividend >> SH;
         rem_in = RW'(dividend & 32'(DIVISOR - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/ffca_mem.sv
// Chunk header store: synchronous RAM, one write and one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module ffca_mem #(
   parameter int unsigned DEPTH = 4096,
   parameter int unsigned DW    = 27,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/first_fit_chunk_allocator.sv
// First-fit chunk allocator top level: command sequencer, registers, header store.
// Uses ffca_pkg, ffca_div and ffca_mem.
`timescale 1ns / 1ps
// Every command first forms its unit count or unit offset with a shift and mask by
// UNIT_BYTES, which must be a power of two. An allocate then walks the chunk chain with one
// RAM read per chunk header visited, then writes the header back and forms the address,
// splitting the chunk when more than two units would be left over. A failed allocate ends
// when the walk runs off the region or meets an invalid header. A free checks the header
// and then runs up to two merge passes; a bad free ends at the offset or header check. The
// result strobe rsp_valid is registered, lasts one cycle and cannot be held off; busy stays
// high through it. After reset and after every region_units write the store is cleared in a
// pass over all MAX_UNITS entries with busy high; configuration writes are always taken.
module first_fit_chunk_allocator
   import ffca_pkg::*;
#(
   parameter int unsigned UNIT_BYTES = 16,
   parameter int unsigned MAX_UNITS  = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req,
   output logic        rsp_valid,
   output rsp_type     rsp,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam int IW = $clog2(MAX_UNITS);
   localparam int LW = $clog2(MAX_UNITS + 1);
   localparam int HW = LW + 1;
   localparam int EW = 2 + LW + IW;
   localparam int CW = (LW > NEED_W) ? LW : NEED_W;
   localparam int PW = HW + $clog2(UNIT_BYTES + 1);
   localparam int RW = $clog2(UNIT_BYTES) + 1;
   localparam int unsigned RESET_UNITS = (MAX_UNITS < 4096) ? MAX_UNITS : 4096;

   typedef enum logic [16:0] {
      S_IDLE   = 17'h00001,
      S_DIV    = 17'h00002,
      S_WRD    = 17'h00004,
      S_WCHK   = 17'h00008,
      S_SWS    = 17'h00010,
      S_SRA    = 17'h00020,
      S_SWA    = 17'h00040,
      S_AWH    = 17'h00080,
      S_ADDR   = 17'h00100,
      S_FRD    = 17'h00200,
      S_FCHK   = 17'h00400,
      S_ABRD   = 17'h00800,
      S_ABCHK  = 17'h01000,
      S_ABNCHK = 17'h02000,
      S_ABWX   = 17'h04000,
      S_ABNN   = 17'h08000,
      S_ABEND  = 17'h10000
   } state_type;

   state_type state_ff, state_in;
   logic              resp_ff, resp_in;
   logic              cmd_ff, cmd_in;
   logic [HW-1:0]     h_ff, h_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [LW-1:0]     len_ff, len_in;
   logic [IW-1:0]     prev_ff, prev_in;
   logic              split_ff, split_in;
   logic [HW-1:0]     aft_ff, aft_in;
   logic [HW-1:0]     x_ff, x_in;
   logic [LW-1:0]     lenx_ff, lenx_in;
   logic [IW-1:0]     prevx_ff, prevx_in;
   logic [LW-1:0]     newlen_ff, newlen_in;
   logic [IW-1:0]     prevh_ff, prevh_in;
   logic              pass2_ff, pass2_in;
   logic [1:0]        status_ff, status_in;
   logic [31:0]       addr_ff, addr_in;
   logic [PW-1:0]     prod_ff, prod_in;
   logic [LW-1:0]     units_ff, units_in;
   logic [31:0]       base_ff, base_in;
   logic              clr_ff, clr_in;
   logic [IW-1:0]     clr_cnt_ff, clr_cnt_in;

   logic          mem_we, mem_re;
   logic [IW-1:0] mem_waddr, mem_raddr;
   logic [EW-1:0] mem_wdata, mem_rdata;
   logic          rd_v, rd_u;
   logic [LW-1:0] rd_len;
   logic [IW-1:0] rd_prev;

   logic          div_start, div_done;
   logic [31:0]   div_dividend, div_quo;
   logic [RW-1:0] div_rem;

   logic          accept;
   logic [HW-1:0] sum_h;
   logic [12:0]   csr_units;

   function automatic logic [EW-1:0] pack_entry(logic v, logic u, logic [LW-1:0] len,
                                                 logic [IW-1:0] prev);
      return {v, u, len, prev};
   endfunction

   ffca_div #(.DIVISOR(UNIT_BYTES)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   ffca_mem #(.DEPTH(MAX_UNITS), .DW(EW)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rd_v    = mem_rdata[EW-1];
   assign rd_u    = mem_rdata[EW-2];
   assign rd_len  = mem_rdata[LW+IW-1:IW];
   assign rd_prev = mem_rdata[IW-1:0];

   assign busy      = (state_ff != S_IDLE) || clr_ff || resp_ff;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign csr_units = csr_data[12:0];

   always_comb begin
      state_in   = state_ff;
      resp_in    = 1'b0;
      cmd_in     = cmd_ff;
      h_in       = h_ff;
      need_in    = need_ff;
      len_in     = len_ff;
      prev_in    = prev_ff;
      split_in   = split_ff;
      aft_in     = aft_ff;
      x_in       = x_ff;
      lenx_in    = lenx_ff;
      prevx_in   = prevx_ff;
      newlen_in  = newlen_ff;
      prevh_in   = prevh_ff;
      pass2_in   = pass2_ff;
      status_in  = status_ff;
      addr_in    = addr_ff;
      prod_in    = prod_ff;
      units_in   = units_ff;
      base_in    = base_ff;
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      mem_we     = 1'b0;
      mem_waddr  = '0;
      mem_wdata  = '0;
      mem_re     = 1'b0;
      mem_raddr  = '0;
      div_start  = 1'b0;
      div_dividend = 32'(req.request_bytes) + 32'(UNIT_BYTES - 1);
      sum_h      = h_ff + HW'(rd_len);

      // config writes
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_BASE) begin
            base_in = csr_data;
         end else begin
            if (csr_units < 13'd2) begin
               units_in = LW'(2);
            end else if (32'(csr_units) > 32'(MAX_UNITS)) begin
               units_in = LW'(MAX_UNITS);
            end else begin
               units_in = LW'(csr_units);
            end
            clr_in     = 1'b1;
            clr_cnt_in = '0;
         end
      end

      // store clearing pass
      if (clr_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = (clr_cnt_ff == '0) ? pack_entry(1'b1, 1'b0, units_ff, '0) : '0;
         if (!(csr_valid && csr_index == CSR_UNITS)) begin
            clr_cnt_in = clr_cnt_ff + IW'(1);
            if (clr_cnt_ff == IW'(MAX_UNITS - 1)) begin
               clr_in = 1'b0;
            end
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in    = req.cmd;
               addr_in   = '0;
               pass2_in  = 1'b0;
               div_start = 1'b1;
               if (req.cmd == CMD_FREE) begin
                  div_dividend = req.free_address - base_ff;
               end
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (cmd_ff == CMD_ALLOC) begin
                  need_in  = NEED_W'(div_quo) + NEED_W'(1);
                  h_in     = '0;
                  state_in = S_WRD;
               end else if (div_rem != '0 || div_quo == 32'd0 ||
                            div_quo > 32'(units_ff)) begin
                  status_in = ST_INV;
                  resp_in   = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  h_in     = HW'(div_quo - 32'd1);
                  state_in = S_FRD;
               end
            end
         end
         S_WRD: begin
            if (h_ff >= HW'(units_ff)) begin
               status_in = ST_OOM;
               resp_in   = 1'b1;
               state_in  = S_IDLE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = h_ff[IW-1:0];
               state_in  = S_WCHK;
            end
         end
         S_WCHK: begin
            if (!rd_v || rd_len == '0) begin
               status_in = ST_OOM;
               resp_in   = 1'b1;
               state_in  = S_IDLE;
            end else if (!rd_u && CW'(rd_len) >= CW'(need_ff)) begin
               len_in   = rd_len;
               prev_in  = rd_prev;
               split_in = (CW'(rd_len) - CW'(need_ff)) > CW'(2);
               aft_in   = sum_h;
               state_in = ((CW'(rd_len) - CW'(need_ff)) > CW'(2)) ? S_SWS : S_AWH;
            end else begin
               h_in     = sum_h;
               state_in = S_WRD;
            end
         end
         S_SWS: begin
            mem_we    = 1'b1;
            mem_waddr = IW'(h_ff + HW'(need_ff));
            mem_wdata = pack_entry(1'b1, 1'b0, LW'(CW'(len_ff) - CW'(need_ff)),
                                   h_ff[IW-1:0]);
            state_in  = S_SRA;
         end
         S_SRA: begin
            if (aft_ff < HW'(units_ff)) begin
               mem_re    = 1'b1;
               mem_raddr = aft_ff[IW-1:0];
               state_in  = S_SWA;
            end else begin
               state_in = S_AWH;
            end
         end
         S_SWA: begin
            mem_we    = 1'b1;
            mem_waddr = aft_ff[IW-1:0];
            mem_wdata = pack_entry(rd_v, rd_u, rd_len, IW'(h_ff + HW'(need_ff)));
            state_in  = S_AWH;
         end
         S_AWH: begin
            mem_we    = 1'b1;
            mem_waddr = h_ff[IW-1:0];
            mem_wdata = pack_entry(1'b1, 1'b1, split_ff ? LW'(need_ff) : len_ff, prev_ff);
            prod_in   = PW'(h_ff + HW'(1)) * PW'(UNIT_BYTES);
            state_in  = S_ADDR;
         end
         S_ADDR: begin
            addr_in   = base_ff + 32'(prod_ff);
            status_in = ST_OK;
            resp_in   = 1'b1;
            state_in  = S_IDLE;
         end
         S_FRD: begin
            mem_re    = 1'b1;
            mem_raddr = h_ff[IW-1:0];
            state_in  = S_FCHK;
         end
         S_FCHK: begin
            if (!rd_v || !rd_u) begin
               status_in = ST_INV;
               resp_in   = 1'b1;
               state_in  = S_IDLE;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = h_ff[IW-1:0];
               mem_wdata = pack_entry(1'b1, 1'b0, rd_len, rd_prev);
               prevh_in  = rd_prev;
               x_in      = h_ff;
               state_in  = S_ABRD;
            end
         end
         S_ABRD: begin
            if (x_ff >= HW'(units_ff)) begin
               state_in = S_ABEND;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = x_ff[IW-1:0];
               state_in  = S_ABCHK;
            end
         end
         S_ABCHK: begin
            if (!rd_v || rd_u || (x_ff + HW'(rd_len)) >= HW'(units_ff)) begin
               state_in = S_ABEND;
            end else begin
               lenx_in   = rd_len;
               prevx_in  = rd_prev;
               mem_re    = 1'b1;
               mem_raddr = IW'(x_ff + HW'(rd_len));
               state_in  = S_ABNCHK;
            end
         end
         S_ABNCHK: begin
            if (!rd_v || rd_u) begin
               state_in = S_ABEND;
            end else begin
               newlen_in = lenx_ff + rd_len;
               mem_we    = 1'b1;
               mem_waddr = IW'(x_ff + HW'(lenx_ff));
               mem_wdata = '0;
               state_in  = S_ABWX;
            end
         end
         S_ABWX: begin
            mem_we    = 1'b1;
            mem_waddr = x_ff[IW-1:0];
            mem_wdata = pack_entry(1'b1, 1'b0, newlen_ff, prevx_ff);
            if ((x_ff + HW'(newlen_ff)) < HW'(units_ff)) begin
               mem_re    = 1'b1;
               mem_raddr = IW'(x_ff + HW'(newlen_ff));
               state_in  = S_ABNN;
            end else begin
               state_in = S_ABEND;
            end
         end
         S_ABNN: begin
            mem_we    = 1'b1;
            mem_waddr = IW'(x_ff + HW'(newlen_ff));
            mem_wdata = pack_entry(rd_v, rd_u, rd_len, x_ff[IW-1:0]);
            state_in  = S_ABEND;
         end
         S_ABEND: begin
            if (!pass2_ff && h_ff != '0) begin
               pass2_in = 1'b1;
               x_in     = HW'(prevh_ff);
               state_in = S_ABRD;
            end else begin
               status_in = ST_OK;
               resp_in   = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         resp_ff    <= 1'b0;
         units_ff   <= LW'(RESET_UNITS);
         base_ff    <= '0;
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
         pass2_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         resp_ff    <= resp_in;
         units_ff   <= units_in;
         base_ff    <= base_in;
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
         pass2_ff   <= pass2_in;
      end
      cmd_ff    <= cmd_in;
      h_ff      <= h_in;
      need_ff   <= need_in;
      len_ff    <= len_in;
      prev_ff   <= prev_in;
      split_ff  <= split_in;
      aft_ff    <= aft_in;
      x_ff      <= x_in;
      lenx_ff   <= lenx_in;
      prevx_ff  <= prevx_in;
      newlen_ff <= newlen_in;
      prevh_ff  <= prevh_in;
      status_ff <= status_in;
      addr_ff   <= addr_in;
      prod_ff   <= prod_in;
   end

   assign rsp_valid        = resp_ff;
   assign rsp.status       = status_ff;
   assign rsp.user_address = addr_ff;

   a_one_cycle_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accepted command");

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> (state_ff == S_IDLE))
      else $error("command running during store clear");

   a_ok_address: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status != ST_OK) |-> (rsp.user_address == 32'd0))
      else $error("nonzero address on failed command");

endmodule
